// ===== hw/rtl/itp_pkg.sv =====
// Shared types, constants and helpers for the integer text parser.
// Used by itp_front, itp_back and integer_text_parser_core.
`timescale 1ns / 1ps

package itp_pkg;

	localparam int MAX_CHARS = 4096;
	localparam int OFF_W     = 13;
	localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_CHARS);

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int RQ_DEPTH = 2;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam int RADIX_W = 6;

	typedef enum logic [0:0] {
		REG_RADIX  = 1'b0,
		REG_SIGNED = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_START,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic [63:0]      value;
		logic [OFF_W-1:0] end_offset;
		logic             any_digits;
	} result_t;

	// Character class as handed from front to back
	typedef struct packed {
		logic [RADIX_W-1:0] digit;
		logic               is_digit;
		logic               is_space;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               last;
	} char_class_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               signed_mode;
	} cfg_t;

	// Result before the sign is applied
	typedef struct packed {
		logic [63:0]      acc;
		logic             neg;
		logic [OFF_W-1:0] end_offset;
		logic             any_digits;
	} raw_result_t;

	function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] x);
		return (x >= MAX_OFF) ? x : x + 1'b1;
	endfunction

endpackage

// ===== hw/rtl/itp_front.sv =====
// Front end: classifies each incoming character and queues the class.
// Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_front import itp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  char_item_t  char_item,
	input  logic        deq,
	output logic        cls_valid,
	output char_class_t cls
);

	char_class_t          fq_mem [FQ_DEPTH];
	logic [FQ_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [FQ_AW:0]       fq_cnt_q;
	logic                 do_push, do_pop;
	char_class_t          cls_new;

	always_comb begin
		logic [7:0] c;
		c = char_item.ch;
		cls_new          = '0;
		cls_new.last     = char_item.last;
		cls_new.is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		cls_new.is_plus  = (c == "+");
		cls_new.is_minus = (c == "-");
		cls_new.is_zero  = (c == "0");
		cls_new.is_x     = (c == "x") || (c == "X");
		if (c >= "0" && c <= "9") begin
			cls_new.is_digit = 1'b1;
			cls_new.digit    = RADIX_W'(c - 8'h30);
		end else if (c >= "a" && c <= "z") begin
			cls_new.is_digit = 1'b1;
			cls_new.digit    = RADIX_W'(c - 8'h61 + 8'd10);
		end else if (c >= "A" && c <= "Z") begin
			cls_new.is_digit = 1'b1;
			cls_new.digit    = RADIX_W'(c - 8'h41 + 8'd10);
		end
	end

	assign full      = (fq_cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign cls_valid = (fq_cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = deq && cls_valid;
	assign cls       = fq_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			fq_mem[wr_ptr_q] <= cls_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fq_cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      fq_cnt_q <= fq_cnt_q + 1'b1;
			else if (do_pop && !do_push) fq_cnt_q <= fq_cnt_q - 1'b1;
		end
	end

	a_fq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fq_cnt_q <= (FQ_AW+1)'(FQ_DEPTH))
		else $error("front queue count out of range");

	a_fq_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> fq_cnt_q == $past(fq_cnt_q) + 1'b1)
		else $error("front queue count missed a push");

	a_fq_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> fq_cnt_q == $past(fq_cnt_q) - 1'b1)
		else $error("front queue count missed a pop");

endmodule

// ===== hw/rtl/itp_back.sv =====
// Back end: phase machine, accumulator and result queue.
// Depends on itp_pkg; fed by itp_front.
`timescale 1ns / 1ps

module itp_back import itp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cls_valid,
	input  char_class_t cls,
	output logic        cls_pop,
	input  cfg_t        cfg,
	output logic        empty,
	input  logic        pop,
	output result_t     result
);

	phase_t             phase_q, phase_d;
	logic [63:0]        acc_q, acc_d;
	logic [OFF_W-1:0]   pos_q, pos_d;
	logic [OFF_W-1:0]   as_q, as_d;
	logic [OFF_W-1:0]   dend_q, dend_d;
	logic               neg_q, neg_d;
	logic [RADIX_W-1:0] base_q, base_d;
	logic               seen_q, seen_d;

	raw_result_t        rq_mem [RQ_DEPTH];
	logic [RQ_AW-1:0]   rq_wr_q, rq_rd_q;
	logic [RQ_AW:0]     rq_cnt_q;
	logic               rq_full, rq_push, rq_pop;
	raw_result_t        rq_new, rq_head;

	logic               take;
	logic               is_sign, in_space, first_mode, auto_r, hex_r;
	logic               first_zero, zero_x, zero_dig, digit_try, hit;
	logic [RADIX_W-1:0] try_base;
	logic [63:0]        prod;
	logic [63:0]        mac;
	logic               fin_zero, seen_fin;
	logic [OFF_W-1:0]   dend_fin;

	assign rq_full = (rq_cnt_q == (RQ_AW+1)'(RQ_DEPTH));
	assign take    = cls_valid && (!cls.last || !rq_full);
	assign cls_pop = take;

	// Character decode against current phase
	assign is_sign    = cls.is_plus || (cls.is_minus && cfg.signed_mode);
	assign in_space   = (phase_q == PH_SPACE);
	assign first_mode = (in_space && !cls.is_space && !is_sign) || (phase_q == PH_START);
	assign auto_r     = (cfg.radix == '0);
	assign hex_r      = (cfg.radix == RADIX_W'(16));
	assign first_zero = first_mode && cls.is_zero && (auto_r || hex_r);
	assign zero_x     = (phase_q == PH_ZERO) && cls.is_x;
	assign zero_dig   = (phase_q == PH_ZERO) && !cls.is_x;
	assign digit_try  = (first_mode && !first_zero) || zero_dig || (phase_q == PH_DIGITS);
	assign try_base   = first_mode ? (auto_r ? RADIX_W'(10) : cfg.radix) : base_q;
	assign hit        = digit_try && cls.is_digit && (cls.digit < try_base);

	assign prod = acc_q * 64'(try_base);
	assign mac  = prod + 64'(cls.digit);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SPACE, PH_START: begin
				if (in_space && is_sign)  phase_d = PH_START;
				else if (first_zero)      phase_d = PH_ZERO;
				else if (digit_try)       phase_d = hit ? PH_DIGITS : PH_DONE;
			end
			PH_ZERO: begin
				if (zero_x) phase_d = PH_DIGITS;
				else        phase_d = hit ? PH_DIGITS : PH_DONE;
			end
			PH_DIGITS: phase_d = hit ? PH_DIGITS : PH_DONE;
			PH_DONE:   phase_d = PH_DONE;
			default:   phase_d = PH_SPACE;
		endcase
	end

	// Datapath updates
	always_comb begin
		acc_d  = hit ? mac : acc_q;
		pos_d  = sat_inc(pos_q);
		as_d   = as_q;
		neg_d  = neg_q;
		base_d = base_q;
		seen_d = seen_q || hit || zero_dig;
		dend_d = dend_q;
		if (in_space) begin
			as_d = (cls.is_space || is_sign) ? sat_inc(pos_q) : pos_q;
		end
		if (in_space && is_sign) begin
			neg_d = cls.is_minus;
		end
		if (first_mode) begin
			base_d = first_zero ? (auto_r ? RADIX_W'(8) : RADIX_W'(16)) : try_base;
		end else if (zero_x) begin
			base_d = RADIX_W'(16);
		end
		if (hit)           dend_d = sat_inc(pos_q);
		else if (zero_dig) dend_d = pos_q;

		// A lone leading zero at the end of the string counts as a digit
		fin_zero = (phase_d == PH_ZERO);
		seen_fin = seen_d || fin_zero;
		dend_fin = fin_zero ? pos_d : dend_d;

		rq_new.acc        = acc_d;
		rq_new.neg        = neg_d;
		rq_new.end_offset = seen_fin ? dend_fin : as_d;
		rq_new.any_digits = seen_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			acc_q   <= '0;
			pos_q   <= '0;
			as_q    <= '0;
			dend_q  <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (cls.last) begin
				phase_q <= PH_SPACE;
				acc_q   <= '0;
				pos_q   <= '0;
				as_q    <= '0;
				dend_q  <= '0;
				neg_q   <= 1'b0;
				base_q  <= '0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				pos_q   <= pos_d;
				as_q    <= as_d;
				dend_q  <= dend_d;
				neg_q   <= neg_d;
				base_q  <= base_d;
				seen_q  <= seen_d;
			end
		end
	end

	// Result queue; sign is applied on the way out
	assign rq_push = take && cls.last;
	assign empty   = (rq_cnt_q == '0);
	assign rq_pop  = pop && !empty;
	assign rq_head = rq_mem[rq_rd_q];

	assign result.value      = rq_head.neg ? (64'd0 - rq_head.acc) : rq_head.acc;
	assign result.end_offset = rq_head.end_offset;
	assign result.any_digits = rq_head.any_digits;

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_mem[rq_wr_q] <= rq_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (rq_push) rq_wr_q <= rq_wr_q + 1'b1;
			if (rq_pop)  rq_rd_q <= rq_rd_q + 1'b1;
			if (rq_push && !rq_pop)      rq_cnt_q <= rq_cnt_q + 1'b1;
			else if (rq_pop && !rq_push) rq_cnt_q <= rq_cnt_q - 1'b1;
		end
	end

	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= (RQ_AW+1)'(RQ_DEPTH))
		else $error("result queue count out of range");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cls.last) |=> (phase_q == PH_SPACE) && (pos_q == '0) && !seen_q)
		else $error("string state not cleared after last item");

	a_acc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q != '0) |-> (phase_q == PH_DIGITS || phase_q == PH_DONE))
		else $error("accumulator nonzero before any digit");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= MAX_OFF) && (dend_q <= MAX_OFF) && (as_q <= MAX_OFF))
		else $error("offset beyond saturation limit");

endmodule

// ===== hw/rtl/integer_text_parser_core.sv =====
// Top level of the integer text parser: config registers, front and back.
// Depends on itp_pkg, itp_front, itp_back.
`timescale 1ns / 1ps

// Streams text one character per item and converts it strtol-style into a
// 64-bit value. Sustained rate is one character per clock unless an item
// marked last waits on a full result queue; the back end does one 64x6
// multiply-add on the accumulator per cycle, and that loop sets the rate. A
// character accepted into the front queue (four entries) is registered there
// before the back end consumes it; the result of an item marked last is
// poppable the cycle after the back end consumes it, from a two-entry result
// queue. full rises only when the front queue backs up behind a stalled result
// queue. Write radix and signed_mode only while no string is in flight.
module integer_text_parser_core import itp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  char_item_t         char_item,
	output logic               empty,
	input  logic               pop,
	output result_t            result,
	input  logic               cfg_we,
	input  reg_idx_t           cfg_idx,
	input  logic [RADIX_W-1:0] cfg_wdata
);

	cfg_t        cfg_q;
	logic        cls_valid, cls_pop;
	char_class_t cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix       <= RADIX_W'(10);
			cfg_q.signed_mode <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RADIX:  cfg_q.radix       <= cfg_wdata;
				REG_SIGNED: cfg_q.signed_mode <= cfg_wdata[0];
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	itp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_item (char_item),
		.deq       (cls_pop),
		.cls_valid (cls_valid),
		.cls       (cls)
	);

	itp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_pop   (cls_pop),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== bench/integer_text_parser_core_tb.sv =====
// Self-checking bench for integer_text_parser_core: character stream in, parse results out.
// Depends on itp_pkg and the RTL of the parser core; needs no files or arguments.
`timescale 1ns / 1ps

module integer_text_parser_core_tb;
	import itp_pkg::*;

	localparam int RUN_LIMIT = 1500000;
	localparam int SETTLE    = 8;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	char_item_t         char_item;
	logic               empty;
	logic               pop;
	result_t            result;
	logic               cfg_we;
	reg_idx_t           cfg_idx;
	logic [RADIX_W-1:0] cfg_wdata;

	integer_text_parser_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_item (char_item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// register shadows
	logic [RADIX_W-1:0] cur_radix;
	logic               cur_signed;

	// per-string parse state
	phase_t           st_phase;
	logic [63:0]      st_acc;
	logic [OFF_W-1:0] st_pos;
	logic [OFF_W-1:0] st_sign_end;
	logic             st_neg;
	logic [RADIX_W-1:0] st_base;
	logic             st_seen;
	logic [OFF_W-1:0] st_digit_end;

	result_t     expected_results[$];
	logic [7:0]  text_buf[$];
	int          fail_count;
	int          chars_sent;
	int          strings_sent;
	int          results_checked;
	int          reg_writes;
	bit          idle_en;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", RUN_LIMIT,
			expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [OFF_W-1:0] clamp_offset(input int x);
		return (x > MAX_CHARS) ? OFF_W'(MAX_CHARS) : OFF_W'(x);
	endfunction

	function automatic int digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "a" && c <= "z") return int'(c) - 97 + 10;
		if (c >= "A" && c <= "Z") return int'(c) - 65 + 10;
		return 255;
	endfunction

	function automatic void clear_parse();
		st_phase     = PH_SPACE;
		st_acc       = '0;
		st_pos       = '0;
		st_sign_end  = '0;
		st_neg       = 1'b0;
		st_base      = '0;
		st_seen      = 1'b0;
		st_digit_end = '0;
	endfunction

	function automatic void accumulate_digit(input logic [7:0] c, input int p);
		int d;
		d = digit_value(c);
		if (d < int'(st_base)) begin
			st_acc       = st_acc * 64'(st_base) + 64'(d);
			st_seen      = 1'b1;
			st_digit_end = clamp_offset(p + 1);
			st_phase     = PH_DIGITS;
		end else begin
			st_phase = PH_DONE;
		end
	endfunction

	// first character after whitespace and sign fixes the base
	function automatic void pick_base(input logic [7:0] c, input int p);
		if (cur_radix == 0) begin
			if (c == "0") begin
				st_base  = 6'd8;
				st_phase = PH_ZERO;
				return;
			end
			st_base = 6'd10;
		end else if (cur_radix == 16 && c == "0") begin
			st_base  = 6'd16;
			st_phase = PH_ZERO;
			return;
		end else begin
			st_base = cur_radix;
		end
		accumulate_digit(c, p);
	endfunction

	function automatic void parse_char(input logic [7:0] c, input logic lst);
		int      p;
		result_t r;
		p = int'(st_pos);
		case (st_phase)
			PH_SPACE: begin
				if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
					st_sign_end = clamp_offset(p + 1);
				end else if (c == "+" || (c == "-" && cur_signed)) begin
					st_neg      = (c == "-");
					st_sign_end = clamp_offset(p + 1);
					st_phase    = PH_START;
				end else begin
					st_sign_end = OFF_W'(p);
					pick_base(c, p);
				end
			end
			PH_START: pick_base(c, p);
			PH_ZERO: begin
				if (c == "x" || c == "X") begin
					st_base  = 6'd16;
					st_phase = PH_DIGITS;
				end else begin
					// the leading zero was a real digit
					st_acc       = '0;
					st_seen      = 1'b1;
					st_digit_end = OFF_W'(p);
					accumulate_digit(c, p);
				end
			end
			PH_DIGITS: accumulate_digit(c, p);
			default: ;
		endcase
		st_pos = clamp_offset(p + 1);
		if (lst) begin
			if (st_phase == PH_ZERO) begin
				st_acc       = '0;
				st_seen      = 1'b1;
				st_digit_end = st_pos;
			end
			r.value      = st_neg ? (64'd0 - st_acc) : st_acc;
			r.end_offset = st_seen ? st_digit_end : st_sign_end;
			r.any_digits = st_seen;
			expected_results.push_back(r);
			clear_parse();
		end
	endfunction

	// called at a falling edge, returns at a falling edge with push still high
	task automatic send_char(input logic [7:0] c, input logic lst);
		int gap;
		if (idle_en && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 14);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		char_item <= {c, lst};
		do @(posedge clk); while (full);
		parse_char(c, lst);
		chars_sent++;
		if (lst) strings_sent++;
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_run(input logic [7:0] c, input int n);
		repeat (n) send_char(c, 1'b0);
	endtask

	task automatic send_buf();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	// hold the sender until every result is back, then let the pipe settle
	task automatic drain();
		push <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [RADIX_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RADIX) cur_radix = data;
		else cur_signed = data[0];
		reg_writes++;
	endtask

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10) return 8'(48 + v);
		return ($urandom_range(0, 1) != 0) ? 8'(97 + v - 10) : 8'(65 + v - 10);
	endfunction

	// mostly well-formed numbers with random content, some noise and broken text
	task automatic make_string();
		string pool;
		int    kind;
		int    eff;
		int    n;
		int    r;
		pool = " +-0xX19aZ\t";
		kind = $urandom_range(0, 9);
		text_buf.delete();
		if (kind == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 1) begin
			n = $urandom_range(1, 8);
			repeat (n) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) begin
				r = $urandom_range(0, 6);
				text_buf.push_back((r == 6) ? 8'd32 : 8'(9 + r));
			end
			r = $urandom_range(0, 2);
			if (r == 1) text_buf.push_back("+");
			if (r == 2) text_buf.push_back("-");
			if (cur_radix == 0) begin
				r = $urandom_range(0, 2);
				if (r == 0) begin
					text_buf.push_back("0");
					text_buf.push_back(($urandom_range(0, 1) != 0) ? "x" : "X");
					eff = 16;
				end else if (r == 1) begin
					text_buf.push_back("0");
					eff = 8;
				end else begin
					eff = 10;
				end
			end else begin
				if (cur_radix == 16 && $urandom_range(0, 1) != 0) begin
					text_buf.push_back("0");
					text_buf.push_back(($urandom_range(0, 1) != 0) ? "x" : "X");
				end
				eff = (cur_radix > 36) ? 36 : int'(cur_radix);
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
			repeat (n) text_buf.push_back(digit_char($urandom_range(0, eff - 1)));
			if ($urandom_range(0, 2) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 4) == 0) text_buf.push_back(digit_char($urandom_range(0, 9)));
		end
		if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic random_phase(input logic [RADIX_W-1:0] rdx, input logic [RADIX_W-1:0] sgn,
			input int n_chars);
		int start;
		write_reg(REG_RADIX, rdx);
		write_reg(REG_SIGNED, sgn);
		start = chars_sent;
		while (chars_sent - start < n_chars) begin
			make_string();
			send_buf();
		end
	endtask

	task automatic test_decimal_defaults();
		send_str(" \t\n\v\f\r+123");
		send_str("-42");
		send_str("-");
		send_str("   ");
		send_str("+x7");
		send_str("12a");
	endtask

	task automatic test_auto_radix();
		write_reg(REG_RADIX, 6'd0);
		send_str("0x1F");
		send_str("-0XaB");
		send_str("017");
		send_str("0");
		send_str("0xg");
		send_str("09");
	endtask

	task automatic test_hex_radix();
		write_reg(REG_RADIX, 6'd16);
		send_str("0xfF");
		send_str("0");
		send_str("0Xz");
		send_str("1FFFFFFFFFFFFFFFFF");
	endtask

	task automatic test_odd_radix();
		write_reg(REG_RADIX, 6'd1);
		send_str("0010");
		write_reg(REG_RADIX, 6'd36);
		send_str("zZ9");
		write_reg(REG_RADIX, 6'd63);
		send_str("zz.");
		write_reg(REG_RADIX, 6'd2);
		send_str("1012");
	endtask

	task automatic test_unsigned_minus();
		write_reg(REG_RADIX, 6'd10);
		write_reg(REG_SIGNED, 6'h3E);	// bit 0 clear
		send_str("-5");
		send_str("+7");
		write_reg(REG_SIGNED, 6'h3F);
		send_str("-0");
	endtask

	task automatic test_wrap_and_stop();
		send_str("18446744073709551616");
		send_str("-99999999999999999999999");
		// NUL ends conversion, rest is ignored
		send_char("1", 1'b0);
		send_char("2", 1'b0);
		send_char(8'h00, 1'b0);
		send_char("3", 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h80, 1'b1);
	endtask

	task automatic test_long_strings();
		send_run(8'd32, MAX_CHARS + 4);
		send_char("+", 1'b1);
		send_run("9", MAX_CHARS + 4);
		send_char("9", 1'b1);
	endtask

	task automatic test_random();
		random_phase(6'd10, 6'd1, 200);
		random_phase(6'd0, 6'd1, 250);
		random_phase(6'd16, 6'd0, 200);
		random_phase(6'd2, 6'd1, 150);
		random_phase(6'd8, 6'd0, 150);
		random_phase(6'd36, 6'd1, 150);
		random_phase(6'd1, 6'd1, 100);
		random_phase(6'd63, 6'd0, 100);
		random_phase(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 150);
	endtask

	task automatic test_no_idle();
		idle_en = 1'b0;
		random_phase(6'd0, 6'd1, 300);
	endtask

	task automatic check_result(input result_t got);
		result_t exp;
		if (expected_results.size() == 0) begin
			$error("unexpected result: value %h end_offset %0d any_digits %0d",
				got.value, got.end_offset, got.any_digits);
			fail_count++;
			return;
		end
		exp = expected_results.pop_front();
		results_checked++;
		if (got.value !== exp.value) begin
			$error("value: expected %h, got %h", exp.value, got.value);
			fail_count++;
		end
		if (got.end_offset !== exp.end_offset) begin
			$error("end_offset: expected %0d, got %0d", exp.end_offset, got.end_offset);
			fail_count++;
		end
		if (got.any_digits !== exp.any_digits) begin
			$error("any_digits: expected %0d, got %0d", exp.any_digits, got.any_digits);
			fail_count++;
		end
	endtask

	// result side: random pop stalls, check at the rising edge
	initial begin
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) check_result(result);
			@(negedge clk);
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 13);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		char_item  = '0;
		cfg_we     = 1'b0;
		cfg_idx    = REG_RADIX;
		cfg_wdata  = '0;
		cur_radix  = 6'd10;
		cur_signed = 1'b1;
		idle_en    = 1'b1;
		fail_count = 0;
		chars_sent = 0;
		strings_sent = 0;
		results_checked = 0;
		reg_writes = 0;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_decimal_defaults();
		test_auto_radix();
		test_hex_radix();
		test_odd_radix();
		test_unsigned_minus();
		test_wrap_and_stop();
		test_long_strings();
		test_random();
		test_no_idle();

		drain();
		repeat (20) @(negedge clk);
		$display("Sent %0d characters in %0d strings across %0d register writes;",
			chars_sent, strings_sent, reg_writes);
		$display("checked %0d results incl. prefixes, odd radixes, wraparound and saturation.",
			results_checked);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_front.sv
hw/rtl/itp_back.sv
hw/rtl/integer_text_parser_core.sv
bench/integer_text_parser_core_tb.sv
